@@ src/sat_pkg.sv @@
// Shared types and constants for the sorted array table.
// Used by sat_cell, sorted_array_table_top and the testbench; no dependencies.
`default_nettype none
package sat_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int KEY_W = 32;

    // operation kinds
    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_SEARCH = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    // control broadcast to every cell
    typedef struct packed {
        logic                    cmp;   // capture compare flags
        logic                    ins;   // shift up and insert key
        logic                    rem;   // shift down over index
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
        logic [CNT_W-1:0]        used;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ src/sat_cell.sv @@
// One table cell: holds one key, its compare flags and shift logic.
// Depends on sat_pkg.
`default_nettype none
module sat_cell (
    input  wire logic                             i_clk,
    input  wire sat_pkg::t_cell_ctl               i_ctl,
    input  wire logic [sat_pkg::IDX_W-1:0]        i_pos,
    input  wire logic signed [sat_pkg::KEY_W-1:0] i_lo_key,
    input  wire logic signed [sat_pkg::KEY_W-1:0] i_hi_key,
    input  wire logic                             i_lo_lt,
    output logic signed [sat_pkg::KEY_W-1:0]      o_key,
    output logic                                  o_lt,
    output logic                                  o_bnd,
    output logic                                  o_hit,
    output logic                                  o_sel
);

    logic signed [sat_pkg::KEY_W-1:0] r_key;
    logic                             r_lt;
    logic                             r_eq;
    logic [sat_pkg::CNT_W-1:0]        w_pos;
    logic                             w_valid;

    assign w_pos   = {1'b0, i_pos};
    assign w_valid = w_pos < i_ctl.used;

    // capture compare flags against the operation key
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= w_valid && (r_key < i_ctl.key);
            r_eq <= (r_key == i_ctl.key);
        end
    end

    // boundary: first cell whose key is not below the operation key
    assign o_bnd = !r_lt && ((i_pos == '0) || i_lo_lt);
    assign o_hit = o_bnd && r_eq && w_valid;
    assign o_sel = w_valid && (i_pos == i_ctl.idx);
    assign o_lt  = r_lt;
    assign o_key = r_key;

    // shift keys toward or away from the neighbors
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (o_bnd) begin
                r_key <= i_ctl.key;
            end else if ((i_pos != '0) && !r_lt && (w_pos <= i_ctl.used)) begin
                r_key <= i_lo_key;
            end
        end else if (i_ctl.rem) begin
            if ((w_pos >= {1'b0, i_ctl.idx}) && ((w_pos + 1'b1) < i_ctl.used)) begin
                r_key <= i_hi_key;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/sorted_array_table_top.sv @@
// Sorted key table: a row of sat_cell instances plus sequencing and result register.
// An accepted input beat passes through the compare and apply states before its result is valid.
// One operation at a time (capture, compare, apply), accepted only in idle; the cell compare-flag
// register must settle before the cells shift, and a stalled result beat holds apply.
// Reset clears the entry count, sequencer and output valid; stored keys stay undefined.
// Depends on sat_pkg and sat_cell.
`default_nettype none
module sorted_array_table_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [1:0]                       i_kind,
    input  wire logic signed [31:0]               i_key,
    input  wire logic [5:0]                       i_index,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [1:0]                            o_status,
    output logic [5:0]                            o_position,
    output logic signed [31:0]                    o_read_key,
    output logic [6:0]                            o_entries
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                            r_state, n_state;
    sat_pkg::t_kind                    r_kind;
    logic signed [sat_pkg::KEY_W-1:0]  r_key;
    logic [sat_pkg::IDX_W-1:0]         r_idx;
    logic [sat_pkg::CNT_W-1:0]         r_used, n_used;
    logic                              r_out_valid;
    sat_pkg::t_status                  n_status;
    logic [sat_pkg::IDX_W-1:0]         n_position;
    logic signed [sat_pkg::KEY_W-1:0]  n_read_key;

    sat_pkg::t_cell_ctl                w_ctl;
    logic signed [sat_pkg::KEY_W-1:0]  w_cell_key [sat_pkg::DEPTH];
    logic [sat_pkg::DEPTH-1:0]         w_lt, w_bnd, w_hit, w_sel;
    logic                              w_advance, w_apply;
    logic                              w_full, w_idx_ok, w_found;
    logic [sat_pkg::IDX_W-1:0]         w_bnd_pos;
    logic signed [sat_pkg::KEY_W-1:0]  w_sel_key;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_apply    = (r_state == S_APPLY) && w_advance;
    assign w_full     = (r_used >= sat_pkg::CNT_W'(sat_pkg::DEPTH));
    assign w_idx_ok   = ({1'b0, r_idx} < r_used);

    // drive the cell control bundle
    always_comb begin
        w_ctl.cmp  = (r_state == S_CMP);
        w_ctl.ins  = w_apply && (r_kind == sat_pkg::K_INSERT) && !w_full;
        w_ctl.rem  = w_apply && (r_kind == sat_pkg::K_REMOVE) && w_idx_ok;
        w_ctl.key  = r_key;
        w_ctl.idx  = r_idx;
        w_ctl.used = r_used;
    end

    // row of cells, each linked to its two neighbors
    for (genvar g = 0; g < sat_pkg::DEPTH; g++) begin : g_cell
        logic signed [sat_pkg::KEY_W-1:0] w_lo_key, w_hi_key;
        logic                             w_lo_lt;
        if (g == 0) begin : g_first
            assign w_lo_key = '0;
            assign w_lo_lt  = 1'b0;
        end else begin : g_mid
            assign w_lo_key = w_cell_key[g-1];
            assign w_lo_lt  = w_lt[g-1];
        end
        if (g == sat_pkg::DEPTH - 1) begin : g_last
            assign w_hi_key = '0;
        end else begin : g_up
            assign w_hi_key = w_cell_key[g+1];
        end
        sat_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_pos    (sat_pkg::IDX_W'(g)),
            .i_lo_key (w_lo_key),
            .i_hi_key (w_hi_key),
            .i_lo_lt  (w_lo_lt),
            .o_key    (w_cell_key[g]),
            .o_lt     (w_lt[g]),
            .o_bnd    (w_bnd[g]),
            .o_hit    (w_hit[g]),
            .o_sel    (w_sel[g])
        );
    end

    // gather boundary position and selected key from the one-hot cell flags
    always_comb begin
        w_bnd_pos = '0;
        w_sel_key = '0;
        for (int i = 0; i < sat_pkg::DEPTH; i++) begin
            w_bnd_pos = w_bnd_pos | (w_bnd[i] ? sat_pkg::IDX_W'(i) : '0);
            w_sel_key = w_sel_key | (w_sel[i] ? w_cell_key[i] : '0);
        end
        w_found = |w_hit;
    end

    // form the result beat and next entry count
    always_comb begin
        n_status   = sat_pkg::ST_OK;
        n_position = '0;
        n_read_key = '0;
        n_used     = r_used;
        unique case (r_kind)
            sat_pkg::K_INSERT: begin
                if (w_full) begin
                    n_status = sat_pkg::ST_FULL;
                end else begin
                    n_position = w_bnd_pos;
                    n_used     = r_used + 1'b1;
                end
            end
            sat_pkg::K_REMOVE: begin
                if (!w_idx_ok) begin
                    n_status = sat_pkg::ST_BAD;
                end else begin
                    n_position = r_idx;
                    n_used     = r_used - 1'b1;
                end
            end
            sat_pkg::K_SEARCH: begin
                if (r_used == '0) begin
                    n_status = sat_pkg::ST_BAD;
                end else if (w_found) begin
                    n_position = w_bnd_pos;
                end else begin
                    n_status = sat_pkg::ST_MISS;
                end
            end
            sat_pkg::K_READ: begin
                if (!w_idx_ok) begin
                    n_status = sat_pkg::ST_BAD;
                end else begin
                    n_position = r_idx;
                    n_read_key = w_sel_key;
                end
            end
            default: begin
                n_status = sat_pkg::ST_BAD;
            end
        endcase
    end

    // sequence: capture, compare, apply
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: if (w_advance) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the accepted operation
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= sat_pkg::t_kind'(i_kind);
            r_key  <= i_key;
            r_idx  <= i_index;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            o_status   <= n_status;
            o_position <= n_position;
            o_read_key <= n_read_key;
            o_entries  <= n_used;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ tb/sorted_array_table_top_tb.sv @@
// Testbench for sorted_array_table_top: directed and random insert/remove/search/read beats.
// Self-checking against an in-bench model of the sorted table; depends on sat_pkg and the RTL.
`timescale 1ns / 100ps
module sorted_array_table_top_tb;

    localparam int STALL_LIMIT = 2000;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_ONE = 32'sh0001_0000;  // 1.0 in Q16.16
    localparam logic signed [31:0] KEY_NEG = 32'shFFFF_FFFF;  // smallest negative step

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    typedef struct packed {
        sat_pkg::t_status   status;
        logic [5:0]         position;
        logic signed [31:0] read_key;
        logic [6:0]         entries;
    } t_table_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_kind = 2'd0;
    logic signed [31:0] i_key = 32'sd0;
    logic [5:0]         i_index = 6'd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [5:0]         o_position;
    logic signed [31:0] o_read_key;
    logic [6:0]         o_entries;

    // model of the stored table and its occupancy
    logic signed [31:0] table_keys [0:sat_pkg::DEPTH-1];
    int                 n_keys = 0;
    int                 peak_keys = 0;

    t_table_result      expected_results [$];
    t_table_result      oldest;
    int                 n_err = 0;
    int                 n_by_kind [4] = '{0, 0, 0, 0};
    int                 n_by_status [4] = '{0, 0, 0, 0};

    // sender pacing
    int                 burst_left = 0;
    bit                 steady_tx = 1'b0;

    // receiver stall pattern
    int                 rx_mode = 0;
    int                 rx_left = 0;
    int                 rx_phase = 0;

    int                 idle_cycles = 0;

    sorted_array_table_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_read_key  (o_read_key),
        .o_entries   (o_entries)
    );

    always #5 i_clk = ~i_clk;

    // first position whose key is not below k; the table is kept sorted
    function automatic int lower_bound_pos(logic signed [31:0] k);
        int i;
        for (i = 0; i < n_keys; i++) begin
            if (!(table_keys[i] < k))
                return i;
        end
        return n_keys;
    endfunction

    // apply one operation to the model table and return the result it yields
    function automatic t_table_result apply_table_op(sat_pkg::t_kind op,
                                                     logic signed [31:0] k,
                                                     logic [5:0] ix);
        t_table_result r;
        int            p;
        int            i;
        r.status   = sat_pkg::ST_OK;
        r.position = '0;
        r.read_key = '0;
        case (op)
            sat_pkg::K_INSERT: begin
                if (n_keys >= sat_pkg::DEPTH) begin
                    r.status = sat_pkg::ST_FULL;
                end else begin
                    p = lower_bound_pos(k);
                    for (i = n_keys; i > p; i--)
                        table_keys[i] = table_keys[i-1];
                    table_keys[p] = k;
                    n_keys++;
                    r.position = p[5:0];
                end
            end
            sat_pkg::K_REMOVE: begin
                if (ix >= n_keys) begin
                    r.status = sat_pkg::ST_BAD;
                end else begin
                    for (i = ix; i + 1 < n_keys; i++)
                        table_keys[i] = table_keys[i+1];
                    n_keys--;
                    r.position = ix;
                end
            end
            sat_pkg::K_SEARCH: begin
                if (n_keys == 0) begin
                    r.status = sat_pkg::ST_BAD;
                end else begin
                    p = lower_bound_pos(k);
                    if (p < n_keys && table_keys[p] == k)
                        r.position = p[5:0];
                    else
                        r.status = sat_pkg::ST_MISS;
                end
            end
            default: begin
                if (ix >= n_keys) begin
                    r.status = sat_pkg::ST_BAD;
                end else begin
                    r.read_key = table_keys[ix];
                    r.position = ix;
                end
            end
        endcase
        r.entries = n_keys[6:0];
        return r;
    endfunction

    // favor keys already stored and their neighbors so searches hit and duplicates form
    function automatic logic signed [31:0] pick_key();
        int                 r;
        logic signed [31:0] k;
        r = $urandom_range(0, 99);
        if (n_keys > 0 && r < 40) begin
            k = table_keys[$urandom_range(0, n_keys - 1)];
            case ($urandom_range(0, 5))
                0: k = k + 32'sd1;
                1: k = k - 32'sd1;
                default: ;
            endcase
            return k;
        end
        if (r < 55) begin
            case ($urandom_range(0, 5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 32'sd0;
                3: return KEY_NEG;
                4: return 32'sd1;
                default: return KEY_ONE;
            endcase
        end
        return $urandom;
    endfunction

    // mostly a valid position, sometimes anywhere in the index range
    function automatic logic [5:0] pick_index();
        if (n_keys > 0 && $urandom_range(0, 99) < 80)
            return 6'($urandom_range(0, n_keys - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    // send one operation beat, pausing between bursts unless the sender runs steady
    task automatic send_op(sat_pkg::t_kind op, logic signed [31:0] k, logic [5:0] ix);
        int            gap;
        t_table_result r;
        if (!steady_tx) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_kind     <= op;
        i_key      <= k;
        i_index    <= ix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = apply_table_op(op, k, ix);
        expected_results.push_back(r);
        n_by_kind[op]++;
        n_by_status[r.status]++;
        if (n_keys > peak_keys)
            peak_keys = n_keys;
    endtask

    // hold the sender until every outstanding result beat has arrived
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // operations on the empty table all report a bad index or empty table
    task automatic test_empty_table();
        send_op(sat_pkg::K_REMOVE, 32'sd0, 6'd0);
        send_op(sat_pkg::K_READ, 32'sd0, 6'd0);
        send_op(sat_pkg::K_SEARCH, 32'sd0, 6'd0);
        send_op(sat_pkg::K_READ, KEY_MIN, 6'd63);
        send_op(sat_pkg::K_REMOVE, KEY_MAX, 6'd63);
    endtask

    // extreme keys and duplicates; a duplicate lands ahead of equal keys
    task automatic test_insert_extremes();
        send_op(sat_pkg::K_INSERT, KEY_ONE, 6'd0);
        send_op(sat_pkg::K_INSERT, KEY_MIN, 6'd63);
        send_op(sat_pkg::K_INSERT, KEY_MAX, 6'd0);
        send_op(sat_pkg::K_INSERT, KEY_NEG, 6'd0);
        send_op(sat_pkg::K_INSERT, KEY_ONE, 6'd0);
        send_op(sat_pkg::K_INSERT, KEY_MAX, 6'd0);
        send_op(sat_pkg::K_INSERT, 32'sd0, 6'd0);
    endtask

    // hits at both ends, first of duplicates, and absent keys
    task automatic test_search();
        send_op(sat_pkg::K_SEARCH, KEY_MIN, 6'd0);
        send_op(sat_pkg::K_SEARCH, KEY_MAX, 6'd0);
        send_op(sat_pkg::K_SEARCH, KEY_ONE, 6'd0);
        send_op(sat_pkg::K_SEARCH, 32'sh0002_0000, 6'd0);
        send_op(sat_pkg::K_SEARCH, 32'sh8000_0001, 6'd0);
        send_op(sat_pkg::K_SEARCH, KEY_NEG, 6'd0);
    endtask

    // reads and removes at first, last, middle and past-the-end positions
    task automatic test_read_remove();
        send_op(sat_pkg::K_READ, 32'sd0, 6'd0);
        send_op(sat_pkg::K_READ, 32'sd0, 6'd6);
        send_op(sat_pkg::K_READ, 32'sd0, 6'd7);
        send_op(sat_pkg::K_READ, 32'sd0, 6'd63);
        send_op(sat_pkg::K_REMOVE, 32'sd0, 6'd6);
        send_op(sat_pkg::K_REMOVE, 32'sd0, 6'd0);
        send_op(sat_pkg::K_REMOVE, 32'sd0, 6'd2);
        send_op(sat_pkg::K_REMOVE, 32'sd0, 6'd63);
        send_op(sat_pkg::K_READ, 32'sd0, 6'd0);
    endtask

    // fill to capacity, hit the full case, then empty the table again
    task automatic test_fill_and_full();
        while (n_keys < sat_pkg::DEPTH)
            send_op(sat_pkg::K_INSERT, pick_key(), pick_index());
        send_op(sat_pkg::K_INSERT, KEY_MIN, 6'd0);
        send_op(sat_pkg::K_INSERT, KEY_MAX, 6'd0);
        send_op(sat_pkg::K_INSERT, pick_key(), 6'd0);
        send_op(sat_pkg::K_READ, 32'sd0, 6'd63);
        send_op(sat_pkg::K_SEARCH, table_keys[sat_pkg::DEPTH-1], 6'd0);
        send_op(sat_pkg::K_REMOVE, 32'sd0, 6'd63);
        send_op(sat_pkg::K_INSERT, KEY_MAX, 6'd0);
        send_op(sat_pkg::K_INSERT, 32'sd0, 6'd0);
        send_op(sat_pkg::K_READ, 32'sd0, 6'd0);
        while (n_keys > 0)
            send_op(sat_pkg::K_REMOVE, pick_key(), 6'($urandom_range(0, n_keys - 1)));
        send_op(sat_pkg::K_REMOVE, 32'sd0, 6'd0);
        send_op(sat_pkg::K_SEARCH, KEY_ONE, 6'd0);
    endtask

    // random operations in phases that grow, shrink or churn the table
    task automatic test_random_mix(int n_items);
        int             done;
        int             phase_len;
        int             j;
        int             r;
        t_mix           mix;
        sat_pkg::t_kind op;
        done = 0;
        while (done < n_items) begin
            phase_len = $urandom_range(40, 120);
            mix = t_mix'($urandom_range(0, 2));
            steady_tx = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                drain_results();
            for (j = 0; j < phase_len && done < n_items; j++) begin
                r = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:   op = (r < 55) ? sat_pkg::K_INSERT :
                                     (r < 65) ? sat_pkg::K_REMOVE :
                                     (r < 85) ? sat_pkg::K_SEARCH : sat_pkg::K_READ;
                    MIX_SHRINK: op = (r < 10) ? sat_pkg::K_INSERT :
                                     (r < 65) ? sat_pkg::K_REMOVE :
                                     (r < 85) ? sat_pkg::K_SEARCH : sat_pkg::K_READ;
                    default:    op = (r < 30) ? sat_pkg::K_INSERT :
                                     (r < 55) ? sat_pkg::K_REMOVE :
                                     (r < 80) ? sat_pkg::K_SEARCH : sat_pkg::K_READ;
                endcase
                send_op(op, pick_key(), pick_index());
                done++;
            end
        end
        steady_tx = 1'b0;
    endtask

    // receiver: switch between always-ready, light, heavy and periodic stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= (rx_phase == 6) ? 0 : rx_phase + 1;
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 99) < 75);
            2: i_out_ready <= ($urandom_range(0, 99) < 25);
            default: i_out_ready <= (rx_phase < 3);
        endcase
    end

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, status %0d position %0d entries %0d",
                         $time, o_status, o_position, o_entries);
                n_err++;
            end else begin
                oldest = expected_results.pop_front();
                if (o_status !== oldest.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, o_status);
                    n_err++;
                end
                if (o_position !== oldest.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, oldest.position, o_position);
                    n_err++;
                end
                if (o_read_key !== oldest.read_key) begin
                    $display("%0t: read_key expected %h actual %h",
                             $time, oldest.read_key, o_read_key);
                    n_err++;
                end
                if (o_entries !== oldest.entries) begin
                    $display("%0t: entries expected %0d actual %0d",
                             $time, oldest.entries, o_entries);
                    n_err++;
                end
            end
        end
    end

    // count cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stop a hung run
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_results.size());
        $display("FAIL sorted_array_table_top");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_insert_extremes();
        test_search();
        test_read_remove();
        drain_results();
        test_fill_and_full();
        drain_results();
        test_random_mix(1500);

        // let the last results come out, then allow for the pipeline
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d inserts, %0d removes, %0d searches, %0d reads; peak %0d entries.",
                 n_by_kind[sat_pkg::K_INSERT], n_by_kind[sat_pkg::K_REMOVE],
                 n_by_kind[sat_pkg::K_SEARCH], n_by_kind[sat_pkg::K_READ], peak_keys);
        $display("Statuses seen: ok %0d, full %0d, bad index %0d, not found %0d; errors %0d.",
                 n_by_status[sat_pkg::ST_OK], n_by_status[sat_pkg::ST_FULL],
                 n_by_status[sat_pkg::ST_BAD], n_by_status[sat_pkg::ST_MISS], n_err);
        if (n_err == 0)
            $display("PASS sorted_array_table_top");
        else
            $display("FAIL sorted_array_table_top");
        $finish;
    end

endmodule
